@@ src/vols_pkg.sv @@
`default_nettype none

package vols_pkg;

  localparam int unsigned DEF_NUM_VALVES = 16;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned TICK_W         = 16;
  localparam int unsigned MASK_W         = 16;
  localparam int unsigned NV_W           = 4;
  localparam int unsigned IDX_IN_W       = 8;
  localparam int unsigned CFG_ADDR_W     = 8;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned OUT_DATA_W     = 32;

  localparam logic [CNT_W-1:0]  RST_MAX_OPENING   = CNT_W'(1);
  localparam logic [TICK_W-1:0] RST_OPENING_TICKS = TICK_W'(1000);
  localparam logic [MASK_W-1:0] RST_PRESENT_MASK  = '1;
  localparam logic              RST_START_OPEN    = 1'b0;

  typedef enum logic [1:0] {
    VM_CLOSED  = 2'd0,
    VM_PENDING = 2'd1,
    VM_OPENING = 2'd2,
    VM_OPEN    = 2'd3
  } valve_mode_e;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_OPEN  = 2'd1,
    FN_CLOSE = 2'd2,
    FN_INIT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_RANGE   = 2'd1,
    STS_NODRIVE = 2'd2
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_OPENING   = 8'd0,
    CFG_OPENING_TICKS = 8'd1,
    CFG_PRESENT_MASK  = 8'd2,
    CFG_START_OPEN    = 8'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_REQ,
    SQ_CNT,
    SQ_FIN,
    SQ_SNP,
    SQ_TOPEN,
    SQ_INIT,
    SQ_RD,
    SQ_EMIT
  } seq_state_e;

  typedef enum logic {
    RET_TICK,
    RET_DONE
  } snp_ret_e;

  typedef struct packed {
    logic [CNT_W-1:0]  max_opening;
    logic [TICK_W-1:0] opening_ticks;
    logic [MASK_W-1:0] present_mask;
    logic              start_open;
  } cfg_t;

  typedef struct packed {
    logic [NV_W-1:0] valve;
    valve_mode_e     mode;
  } note_t;

  typedef struct packed {
    logic              has_note;
    logic [NV_W-1:0]   note_valve;
    valve_mode_e       note_state;
    status_e           status;
    logic [MASK_W-1:0] drive_mask;
    logic [CNT_W-1:0]  opening_count;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

@@ src/vols_note_mem.sv @@
`default_nettype none

module vols_note_mem
  import vols_pkg::*;
#(
  parameter int unsigned DEPTH = 3 * DEF_NUM_VALVES,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire note_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output note_t              rdata_o
);

  note_t mem_q [DEPTH];
  note_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/vols_seq.sv @@
`default_nettype none

module vols_seq
  import vols_pkg::*;
#(
  parameter int unsigned NUM_VALVES = DEF_NUM_VALVES,
  parameter int unsigned NOTE_DEPTH = 3 * DEF_NUM_VALVES
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire func_e               in_func_i,
  input  wire logic [IDX_IN_W-1:0] in_index_i,
  input  wire logic                res_free_i,
  output logic                     res_push_o,
  output result_t                  res_o
);

  localparam int unsigned IDX_W = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;
  localparam int unsigned NA_W  = $clog2(NOTE_DEPTH);
  localparam int unsigned NC_W  = $clog2(NOTE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VALVES - 1);

  function automatic logic [IDX_W-1:0] lowest_set(input logic [NUM_VALVES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = NUM_VALVES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  seq_state_e state_q, state_d;
  snp_ret_e   ret_q, ret_d;
  func_e      func_q, func_d;
  status_e    status_q, status_d;

  logic [IDX_IN_W-1:0]   vi_q, vi_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic [NUM_VALVES-1:0] pend_q, pend_d;
  logic [NUM_VALVES-1:0] act_q, act_d;
  logic [NUM_VALVES-1:0] opn_q, opn_d;
  logic [NUM_VALVES-1:0] exp_q, exp_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NC_W-1:0]       wr_q, wr_d;
  logic [NC_W-1:0]       rd_q, rd_d;
  logic [TICK_W-1:0]     ticks_q [NUM_VALVES];

  logic                  t_we;
  logic [IDX_W-1:0]      t_addr;
  logic [TICK_W-1:0]     t_wdata;
  logic                  nw_en;
  note_t                 nw;
  note_t                 rdata;

  logic [NUM_VALVES-1:0] present;
  logic                  can_start;
  logic [IDX_W-1:0]      pend_lo;
  logic [IDX_W-1:0]      exp_lo;
  logic [IDX_W-1:0]      vsel;
  logic                  in_range;
  logic [TICK_W-1:0]     load_ticks;
  logic [TICK_W-1:0]     tick_cur;
  logic                  emit_last;
  logic                  init_all;

  assign present    = cfg_i.present_mask[NUM_VALVES-1:0];
  assign can_start  = cnt_q < cfg_i.max_opening;
  assign pend_lo    = lowest_set(pend_q);
  assign exp_lo     = lowest_set(exp_q);
  assign vsel       = vi_q[IDX_W-1:0];
  assign in_range   = vi_q < IDX_IN_W'(NUM_VALVES);
  assign load_ticks = (cfg_i.opening_ticks == '0) ? TICK_W'(1) : cfg_i.opening_ticks;
  assign tick_cur   = ticks_q[idx_q];
  assign emit_last  = (wr_q == '0) || (NC_W'(rd_q + NC_W'(1)) == wr_q);
  assign init_all   = cfg_i.start_open;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          case (in_func_i)
            FN_TICK: state_d = SQ_CNT;
            FN_INIT: state_d = SQ_INIT;
            default: state_d = SQ_REQ;
          endcase
        end
      end
      SQ_REQ: begin
        if (in_range && present[vsel] && func_q == FN_CLOSE && opn_q[vsel]) begin
          state_d = SQ_SNP;
        end else begin
          state_d = SQ_RD;
        end
      end
      SQ_CNT: begin
        if (idx_q == LAST_IDX) state_d = SQ_FIN;
      end
      SQ_FIN: begin
        state_d = (exp_q == '0) ? SQ_RD : SQ_SNP;
      end
      SQ_SNP: begin
        if (!(can_start && pend_q != '0) || present[pend_lo]) begin
          state_d = (ret_q == RET_TICK) ? SQ_TOPEN : SQ_RD;
        end
      end
      SQ_TOPEN: state_d = SQ_FIN;
      SQ_INIT: begin
        if (idx_q == LAST_IDX) state_d = SQ_RD;
      end
      SQ_RD:   state_d = SQ_EMIT;
      SQ_EMIT: begin
        if (res_free_i) state_d = emit_last ? SQ_IDLE : SQ_RD;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    ret_d    = ret_q;
    func_d   = func_q;
    status_d = status_q;
    vi_d     = vi_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    pend_d   = pend_q;
    act_d    = act_q;
    opn_d    = opn_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    rd_d     = rd_q;
    t_we     = 1'b0;
    t_addr   = idx_q;
    t_wdata  = load_ticks;
    nw_en    = 1'b0;
    nw       = '{valve: '0, mode: VM_CLOSED};
    case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_func_i;
          vi_d     = in_index_i;
          status_d = STS_OK;
          idx_d    = '0;
          exp_d    = '0;
          rd_d     = '0;
        end
      end
      SQ_REQ: begin
        ret_d = RET_DONE;
        if (!in_range) begin
          status_d = STS_RANGE;
        end else if (!present[vsel]) begin
          status_d = STS_NODRIVE;
        end else if (func_q == FN_CLOSE) begin
          pend_d[vsel] = 1'b0;
          act_d[vsel]  = 1'b0;
          opn_d[vsel]  = 1'b0;
          if (opn_q[vsel]) cnt_d = cnt_q - CNT_W'(1);
          nw_en = 1'b1;
          nw    = '{valve: NV_W'(vsel), mode: VM_CLOSED};
        end else if (!act_q[vsel]) begin
          if (can_start) begin
            pend_d[vsel] = 1'b0;
            act_d[vsel]  = 1'b1;
            opn_d[vsel]  = 1'b1;
            cnt_d        = cnt_q + CNT_W'(1);
            t_we         = 1'b1;
            t_addr       = vsel;
            nw_en        = 1'b1;
            nw           = '{valve: NV_W'(vsel), mode: VM_OPENING};
          end else if (!pend_q[vsel]) begin
            pend_d[vsel] = 1'b1;
            nw_en        = 1'b1;
            nw           = '{valve: NV_W'(vsel), mode: VM_PENDING};
          end
        end
      end
      SQ_CNT: begin
        if (opn_q[idx_q]) begin
          if (tick_cur <= TICK_W'(1)) begin
            exp_d[idx_q] = 1'b1;
          end else begin
            t_we    = 1'b1;
            t_wdata = tick_cur - TICK_W'(1);
          end
        end
        idx_d = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
      end
      SQ_FIN: begin
        ret_d = RET_TICK;
        if (exp_q != '0) begin
          opn_d[exp_lo] = 1'b0;
          exp_d[exp_lo] = 1'b0;
          cnt_d         = cnt_q - CNT_W'(1);
          cur_d         = exp_lo;
        end
      end
      SQ_SNP: begin
        if (can_start && pend_q != '0) begin
          pend_d[pend_lo] = 1'b0;
          nw_en           = 1'b1;
          if (present[pend_lo]) begin
            act_d[pend_lo] = 1'b1;
            opn_d[pend_lo] = 1'b1;
            cnt_d          = cnt_q + CNT_W'(1);
            t_we           = 1'b1;
            t_addr         = pend_lo;
            nw             = '{valve: NV_W'(pend_lo), mode: VM_OPENING};
          end else begin
            nw = '{valve: NV_W'(pend_lo), mode: VM_CLOSED};
          end
        end
      end
      SQ_TOPEN: begin
        nw_en = 1'b1;
        nw    = '{valve: NV_W'(cur_q), mode: VM_OPEN};
      end
      SQ_INIT: begin
        pend_d = '0;
        opn_d  = '0;
        act_d  = init_all ? '1 : '0;
        cnt_d  = '0;
        nw_en  = 1'b1;
        nw     = '{valve: NV_W'(idx_q), mode: init_all ? VM_OPEN : VM_CLOSED};
        idx_d  = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
      end
      SQ_EMIT: begin
        if (res_free_i) rd_d = rd_q + NC_W'(1);
      end
      default: ;
    endcase
  end

  assign wr_d = (state_q == SQ_IDLE) ? '0 : wr_q + NC_W'(nw_en);

  // handshake and result
  always_comb begin
    in_ready_o = (state_q == SQ_IDLE);
    res_push_o = (state_q == SQ_EMIT) && res_free_i;
    res_o.has_note      = (wr_q != '0);
    res_o.note_valve    = (wr_q != '0) ? rdata.valve : '0;
    res_o.note_state    = (wr_q != '0) ? rdata.mode : VM_CLOSED;
    res_o.status        = status_q;
    res_o.drive_mask    = MASK_W'(act_q & present);
    res_o.opening_count = cnt_q;
    res_o.last          = emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      ret_q   <= RET_DONE;
      pend_q  <= '0;
      act_q   <= '0;
      opn_q   <= '0;
      exp_q   <= '0;
      cnt_q   <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pend_q  <= pend_d;
      act_q   <= act_d;
      opn_q   <= opn_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    status_q <= status_d;
    vi_q     <= vi_d;
    cur_q    <= cur_d;
    if (t_we) begin
      ticks_q[t_addr] <= t_wdata;
    end
  end

  vols_note_mem #(
    .DEPTH (NOTE_DEPTH),
    .AW    (NA_W)
  ) u_note_mem (
    .clk_i   (clk_i),
    .we_i    (nw_en),
    .waddr_i (wr_q[NA_W-1:0]),
    .wdata_i (nw),
    .raddr_i (rd_q[NA_W-1:0]),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

@@ src/valve_open_limit_sequencer.sv @@
// Valve bank sequencer with a limit on the number of valves opening at once.
// Input stream: tuser carries the command (tick, open, close, initialise),
// tdata the valve index. Configuration registers are written through the
// cfg channel (index 0 max_opening, 1 opening_ticks, 2 present_mask,
// 3 start_open); the user must write them only while no command is in
// flight, which the block does not enforce; cfg_ready_o is always high.
// Each command yields one result per valve state change, or one result with
// no note, the final one marked with tlast; every result carries the status,
// drive mask and opening count after the whole command.
// One command at a time: tready stays low from acceptance until the last
// result is loaded into the output register. A close of an opening valve
// then starts a pending valve, dropping those whose drive is absent; a tick
// scans every valve, then marks each expired valve open and starts a pending
// valve in its place; initialise sets every valve in turn. Each result is
// read from the registered note buffer and emitted.
// A stalled receiver holds the output register and the sequencer waits.
// Reset closes every valve, clears the opening count and loads the register
// defaults (max_opening 1, opening_ticks 1000, all drives present).
`default_nettype none

module valve_open_limit_sequencer
  import vols_pkg::*;
#(
  parameter int unsigned NUM_VALVES = DEF_NUM_VALVES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IDX_IN_W-1:0]   s_axis_tdata_i,  // [7:0] valve_sel
  input  wire logic [1:0]            s_axis_tuser_i,  // [1:0] func
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [3:0] note_valve, [5:4] note_state, [7:6] status, [23:8] drive_mask,
  // [28:24] opening_count, [31:29] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tuser_o,  // [0] has_note
  output logic                       m_axis_tlast_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NOTE_DEPTH = 3 * NUM_VALVES;

  cfg_t    cfg_q;
  result_t out_q;
  result_t res;
  logic    out_valid_q;
  logic    res_free;
  logic    res_push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_opening   <= RST_MAX_OPENING;
      cfg_q.opening_ticks <= RST_OPENING_TICKS;
      cfg_q.present_mask  <= RST_PRESENT_MASK;
      cfg_q.start_open    <= RST_START_OPEN;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_MAX_OPENING:   cfg_q.max_opening   <= cfg_data_i[CNT_W-1:0];
        CFG_OPENING_TICKS: cfg_q.opening_ticks <= cfg_data_i[TICK_W-1:0];
        CFG_PRESENT_MASK:  cfg_q.present_mask  <= cfg_data_i[MASK_W-1:0];
        CFG_START_OPEN:    cfg_q.start_open    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vols_seq #(
    .NUM_VALVES (NUM_VALVES),
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_func_i  (func_e'(s_axis_tuser_i)),
    .in_index_i (s_axis_tdata_i),
    .res_free_i (res_free),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // output register
  assign res_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.has_note;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {3'b000, out_q.opening_count, out_q.drive_mask, out_q.status,
                            out_q.note_state, out_q.note_valve};

  // a result without a note is always the only result of its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("note-less result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[5:0] == 6'd0))
    else $error("note fields set on a note-less result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[28:24] <= CNT_W'(NUM_VALVES)))
    else $error("opening count beyond valve count");

  // no new command while results of the previous one are still being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res.last) |=> !s_axis_tready_o)
    else $error("input taken before all results issued");

endmodule

`default_nettype wire
